### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/spmq_pkg.sv
`default_nettype none

package spmq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int LEVEL_COUNT = 5;
  localparam int QUEUE_COUNT = LEVEL_COUNT + 1;

  localparam int KEY_W   = KEY_BITS;
  localparam int LEVEL_W = 3;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int RCNT_W  = 3;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int Q_W     = $clog2(QUEUE_COUNT);
  localparam int ADDR_W  = $clog2(QUEUE_COUNT * QUEUE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_LEVEL = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_RM_RD,
    S_RM_CMP,
    S_SH_RD,
    S_SH_WR,
    S_HEAD,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

### design/strict_priority_multi_queue.sv
// channel  direction  handshake          payload
// in       to block   in_valid/in_stall  operation, patient_key, priority_level, express_flag
// out      from block out_valid/out_stall status, served_valid, served_key, removed_count,
//                                        next_valid, next_key
// Pop reads the head of the chosen queue, and reports empty when nothing is held. Remove
// scans the queues in order, reading each entry, and on a match shifts the later entries
// down, removing at most one entry per queue; all traffic goes through the one read port
// and the one write port of the shared key store.
// rst (synchronous) empties all queues; key store contents are not cleared.
// in_stall is high while a word is in work; a waiting output word does not block accept.
`default_nettype none

module strict_priority_multi_queue (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [spmq_pkg::OP_W-1:0]    operation,
  input  wire  [spmq_pkg::KEY_W-1:0]   patient_key,
  input  wire  [spmq_pkg::LEVEL_W-1:0] priority_level,
  input  wire                          express_flag,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [spmq_pkg::STAT_W-1:0]  status,
  output logic                         served_valid,
  output logic [spmq_pkg::KEY_W-1:0]   served_key,
  output logic [spmq_pkg::RCNT_W-1:0]  removed_count,
  output logic                         next_valid,
  output logic [spmq_pkg::KEY_W-1:0]   next_key
);
  import spmq_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] fill [QUEUE_COUNT];
  logic [CNT_W-1:0] fill_next [QUEUE_COUNT];
  logic [PTR_W-1:0] head [QUEUE_COUNT];
  logic [PTR_W-1:0] head_next [QUEUE_COUNT];

  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [LEVEL_W-1:0] level_r;
  logic               express_r;
  logic [Q_W-1:0]     rq, rq_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [RCNT_W-1:0]  rcount, rcount_next;
  logic [STAT_W-1:0]  stat_r, stat_r_next;
  logic               sv_r, sv_r_next;
  logic [KEY_W-1:0]   sk_r, sk_r_next;

  logic               out_valid_next;
  logic [STAT_W-1:0]  status_next;
  logic               served_valid_next;
  logic [KEY_W-1:0]   served_key_next;
  logic [RCNT_W-1:0]  removed_count_next;
  logic               next_valid_next;
  logic [KEY_W-1:0]   next_key_next;

  // key store
  logic [KEY_W-1:0]  mem [QUEUE_COUNT * QUEUE_DEPTH];
  logic [ADDR_W-1:0] raddr, waddr;
  logic [KEY_W-1:0]  rdata, wdata;
  logic              we;

  logic           pick_ok;
  logic [Q_W-1:0] pick_q;
  logic [Q_W-1:0] add_q;
  logic           nextq;

  function automatic logic [ADDR_W-1:0] slot(input logic [Q_W-1:0] q,
                                             input logic [PTR_W-1:0] hd,
                                             input logic [CNT_W-1:0] pos);
    logic [CNT_W:0]    sum;
    logic [ADDR_W-1:0] base;
    sum = (CNT_W+1)'(hd) + (CNT_W+1)'(pos);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    base = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH);
    return base + ADDR_W'(sum);
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // express first, then highest level
  always_comb begin
    pick_ok = 1'b0;
    pick_q  = '0;
    for (int q = 1; q < QUEUE_COUNT; q++) begin
      if (fill[q] != '0) begin
        pick_ok = 1'b1;
        pick_q  = Q_W'(q);
      end
    end
    if (fill[0] != '0) begin
      pick_ok = 1'b1;
      pick_q  = '0;
    end
  end

  assign add_q    = express_r ? '0 : Q_W'(level_r);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next         = state;
    fill_next          = fill;
    head_next          = head;
    rq_next            = rq;
    idx_next           = idx;
    rcount_next        = rcount;
    stat_r_next        = stat_r;
    sv_r_next          = sv_r;
    sk_r_next          = sk_r;
    out_valid_next     = out_valid;
    status_next        = status;
    served_valid_next  = served_valid;
    served_key_next    = served_key;
    removed_count_next = removed_count;
    next_valid_next    = next_valid;
    next_key_next      = next_key;
    raddr              = slot(pick_q, head[pick_q], '0);
    waddr              = slot(add_q, head[add_q], fill[add_q]);
    wdata              = key_r;
    we                 = 1'b0;
    nextq              = 1'b0;

    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next  = S_EXEC;
          rq_next     = '0;
          idx_next    = '0;
          rcount_next = '0;
          stat_r_next = ST_OK;
          sv_r_next   = 1'b0;
          sk_r_next   = '0;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_ADD: begin
            state_next = S_HEAD;
            if (level_r == '0 || level_r > LEVEL_W'(LEVEL_COUNT)) begin
              stat_r_next = ST_BAD_LEVEL;
            end else if (fill[add_q] >= CNT_W'(QUEUE_DEPTH)) begin
              stat_r_next = ST_FULL;
            end else begin
              we                = 1'b1;
              fill_next[add_q]  = fill[add_q] + 1'b1;
            end
          end
          OP_POP: begin
            if (pick_ok) begin
              state_next = S_POP;
            end else begin
              stat_r_next = ST_EMPTY;
              state_next  = S_HEAD;
            end
          end
          OP_REMOVE: state_next = S_RM_RD;
          default:   state_next = S_HEAD;
        endcase
      end
      S_POP: begin
        // rdata holds the head of pick_q
        sv_r_next    = 1'b1;
        sk_r_next    = rdata;
        fill_next[pick_q] = fill[pick_q] - 1'b1;
        if (head[pick_q] == PTR_W'(QUEUE_DEPTH - 1)) begin
          head_next[pick_q] = '0;
        end else begin
          head_next[pick_q] = head[pick_q] + 1'b1;
        end
        state_next = S_HEAD;
      end
      S_RM_RD: begin
        if (idx == fill[rq]) begin
          nextq = 1'b1;
        end else begin
          raddr      = slot(rq, head[rq], idx);
          state_next = S_RM_CMP;
        end
      end
      S_RM_CMP: begin
        if (rdata == key_r) begin
          if ((CNT_W+1)'(idx) + 1'b1 < (CNT_W+1)'(fill[rq])) begin
            state_next = S_SH_RD;
          end else begin
            fill_next[rq] = fill[rq] - 1'b1;
            rcount_next   = rcount + 1'b1;
            nextq         = 1'b1;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_RM_RD;
        end
      end
      S_SH_RD: begin
        raddr      = slot(rq, head[rq], idx + 1'b1);
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        we       = 1'b1;
        waddr    = slot(rq, head[rq], idx);
        wdata    = rdata;
        idx_next = idx + 1'b1;
        if ((CNT_W+1)'(idx) + 2'd2 < (CNT_W+1)'(fill[rq])) begin
          state_next = S_SH_RD;
        end else begin
          fill_next[rq] = fill[rq] - 1'b1;
          rcount_next   = rcount + 1'b1;
          nextq         = 1'b1;
        end
      end
      S_HEAD: state_next = S_FIN;
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          out_valid_next     = 1'b1;
          status_next        = (op_r == OP_REMOVE && rcount == '0) ? ST_NOT_FOUND : stat_r;
          served_valid_next  = sv_r;
          served_key_next    = sk_r;
          removed_count_next = rcount;
          next_valid_next    = pick_ok;
          next_key_next      = pick_ok ? rdata : '0;
          state_next         = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (nextq) begin
      idx_next = '0;
      if (rq == Q_W'(QUEUE_COUNT - 1)) begin
        state_next = S_HEAD;
      end else begin
        rq_next    = rq + 1'b1;
        state_next = S_RM_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int q = 0; q < QUEUE_COUNT; q++) begin
        fill[q] <= '0;
        head[q] <= '0;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      fill      <= fill_next;
      head      <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r      <= operation;
      key_r     <= patient_key;
      level_r   <= priority_level;
      express_r <= express_flag;
    end
    rq            <= rq_next;
    idx           <= idx_next;
    rcount        <= rcount_next;
    stat_r        <= stat_r_next;
    sv_r          <= sv_r_next;
    sk_r          <= sk_r_next;
    status        <= status_next;
    served_valid  <= served_valid_next;
    served_key    <= served_key_next;
    removed_count <= removed_count_next;
    next_valid    <= next_valid_next;
    next_key      <= next_key_next;
  end

endmodule

`default_nettype wire

### design/spmq_checker.sv
`default_nettype none
`include "assert_macros.svh"

module spmq_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire [spmq_pkg::STAT_W-1:0]   status,
  input wire                          served_valid,
  input wire [spmq_pkg::KEY_W-1:0]    served_key,
  input wire [spmq_pkg::RCNT_W-1:0]   removed_count,
  input wire                          next_valid,
  input wire [spmq_pkg::KEY_W-1:0]    next_key
);
  import spmq_pkg::*;

  // a stalled word stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  // only a successful pop serves a key
  `ASSERT_IMPL(a_served_ok, clk, rst, out_valid && served_valid, status == ST_OK && removed_count == '0)
  `ASSERT_IMPL(a_served_zero, clk, rst, out_valid && !served_valid, served_key == '0)
  `ASSERT_IMPL(a_next_zero, clk, rst, out_valid && !next_valid, next_key == '0)
  // a hit on remove reports ok and serves nothing
  `ASSERT_IMPL(a_removed_ok, clk, rst, out_valid && removed_count != '0, status == ST_OK && !served_valid)

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .status        (status),
  .served_valid  (served_valid),
  .served_key    (served_key),
  .removed_count (removed_count),
  .next_valid    (next_valid),
  .next_key      (next_key)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spmq_pkg::*;

  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              served_valid;
    logic [KEY_W-1:0]  served_key;
    logic [RCNT_W-1:0] removed_count;
    logic              next_valid;
    logic [KEY_W-1:0]  next_key;
  } result_t;

  typedef struct {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [LEVEL_W-1:0] level;
    logic               express;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation = '0;
  logic [KEY_W-1:0]    patient_key = '0;
  logic [LEVEL_W-1:0]  priority_level = '0;
  logic                express_flag = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic                served_valid;
  logic [KEY_W-1:0]    served_key;
  logic [RCNT_W-1:0]   removed_count;
  logic                next_valid;
  logic [KEY_W-1:0]    next_key;

  strict_priority_multi_queue u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .patient_key    (patient_key),
    .priority_level (priority_level),
    .express_flag   (express_flag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .served_valid   (served_valid),
    .served_key     (served_key),
    .removed_count  (removed_count),
    .next_valid     (next_valid),
    .next_key       (next_key)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // queue 0 is express, 1..LEVEL_COUNT are the levels
  logic [KEY_W-1:0] queued_keys [QUEUE_COUNT][$];
  result_t          awaited_results [$];
  stim_row_t        directed_rows [$];
  logic [KEY_W-1:0] recent_keys [8];
  int               mismatches = 0;
  int               results_seen = 0;
  int               burst_left = 0;

  function automatic int next_queue();
    int q;
    if (queued_keys[0].size() != 0) return 0;
    for (q = LEVEL_COUNT; q >= 1; q--)
      if (queued_keys[q].size() != 0) return q;
    return -1;
  endfunction

  function automatic result_t serve_order_step(op_t op, logic [KEY_W-1:0] key,
                                               logic [LEVEL_W-1:0] level, logic express);
    result_t r;
    int      target;
    int      head;
    int      q;
    int      i;
    bit      found;
    r = '0;
    case (op)
      OP_ADD: begin
        if (level < 1 || level > LEVEL_COUNT) begin
          r.status = ST_BAD_LEVEL;
        end else begin
          target = express ? 0 : int'(level);
          if (queued_keys[target].size() >= QUEUE_DEPTH) r.status = ST_FULL;
          else queued_keys[target].push_back(key);
        end
      end
      OP_POP: begin
        head = next_queue();
        if (head < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.served_valid = 1'b1;
          r.served_key   = queued_keys[head].pop_front();
        end
      end
      OP_REMOVE: begin
        for (q = 0; q < QUEUE_COUNT; q++) begin
          found = 1'b0;
          for (i = 0; i < queued_keys[q].size() && !found; i++) begin
            if (queued_keys[q][i] == key) begin
              queued_keys[q].delete(i);
              found = 1'b1;
            end
          end
          if (found) r.removed_count = r.removed_count + 1'b1;
        end
        if (r.removed_count == 0) r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    head = next_queue();
    if (head >= 0) begin
      r.next_valid = 1'b1;
      r.next_key   = queued_keys[head][0];
    end
    return r;
  endfunction

  function automatic result_t res(logic [STAT_W-1:0] st, logic sv, logic [KEY_W-1:0] sk,
                                  logic [RCNT_W-1:0] rc, logic nv, logic [KEY_W-1:0] nk);
    result_t r;
    r.status        = st;
    r.served_valid  = sv;
    r.served_key    = sk;
    r.removed_count = rc;
    r.next_valid    = nv;
    r.next_key      = nk;
    return r;
  endfunction

  task automatic add_row(op_t op, logic [KEY_W-1:0] key, logic [LEVEL_W-1:0] level,
                         logic express, bit typed, result_t want);
    stim_row_t row;
    row.op      = op;
    row.key     = key;
    row.level   = level;
    row.express = express;
    row.typed   = typed;
    row.want    = want;
    directed_rows.push_back(row);
  endtask

  // drive one word, hold until taken, then maybe open a gap
  task automatic send_word(op_t op, logic [KEY_W-1:0] key, logic [LEVEL_W-1:0] level,
                           logic express, bit typed, result_t want);
    result_t predicted;
    int      gap;
    in_valid       <= 1'b1;
    operation      <= op;
    patient_key    <= key;
    priority_level <= level;
    express_flag   <= express;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = serve_order_step(op, key, level, express);
    awaited_results.push_back(typed ? want : predicted);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", KEY_W'(want.status), KEY_W'(status));
        check_field("served_valid", KEY_W'(want.served_valid), KEY_W'(served_valid));
        check_field("served_key", want.served_key, served_key);
        check_field("removed_count", KEY_W'(want.removed_count), KEY_W'(removed_count));
        check_field("next_valid", KEY_W'(want.next_valid), KEY_W'(next_valid));
        check_field("next_key", want.next_key, next_key);
      end
    end
  end

  // output stall pattern, with one long hold-off so the block backs up
  initial begin : out_stall_gen
    int  mode;
    int  mode_left;
    bit  held;
    mode      = 0;
    mode_left = 0;
    held      = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t          row;
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [LEVEL_W-1:0] level;
    logic               express;
    bit                 filling;
    int                 pick;
    int                 n;

    add_row(OP_POP,    32'h0,        3'd0, 1'b0, 1, res(ST_EMPTY, 0, 0, 0, 0, 0));
    add_row(OP_REMOVE, 32'hDEADBEEF, 3'd0, 1'b0, 1, res(ST_NOT_FOUND, 0, 0, 0, 0, 0));
    add_row(OP_ADD,    32'h11,       3'd0, 1'b0, 1, res(ST_BAD_LEVEL, 0, 0, 0, 0, 0));
    // bad level wins over the express flag
    add_row(OP_ADD,    32'h22,       3'd6, 1'b1, 1, res(ST_BAD_LEVEL, 0, 0, 0, 0, 0));
    add_row(OP_ADD,    32'h33,       3'd7, 1'b0, 1, res(ST_BAD_LEVEL, 0, 0, 0, 0, 0));
    add_row(OP_NOP,    32'hFFFFFFFF, 3'd7, 1'b1, 1, res(ST_OK, 0, 0, 0, 0, 0));
    add_row(OP_ADD,    32'hFFFFFFFF, 3'd5, 1'b0, 1, res(ST_OK, 0, 0, 0, 1, 32'hFFFFFFFF));
    add_row(OP_ADD,    32'h0,        3'd1, 1'b0, 1, res(ST_OK, 0, 0, 0, 1, 32'hFFFFFFFF));
    add_row(OP_ADD,    32'hA5A5A5A5, 3'd3, 1'b1, 1, res(ST_OK, 0, 0, 0, 1, 32'hA5A5A5A5));
    add_row(OP_POP,    32'h0,        3'd0, 1'b0, 1,
            res(ST_OK, 1, 32'hA5A5A5A5, 0, 1, 32'hFFFFFFFF));
    add_row(OP_POP,    32'h0,        3'd0, 1'b0, 1, res(ST_OK, 1, 32'hFFFFFFFF, 0, 1, 0));
    // same key in every queue, then one remove hits all six
    add_row(OP_ADD,    32'h1234,     3'd5, 1'b1, 0, '0);
    for (n = 1; n <= LEVEL_COUNT; n++)
      add_row(OP_ADD, 32'h1234, LEVEL_W'(n), 1'b0, 0, '0);
    add_row(OP_REMOVE, 32'h1234,     3'd0, 1'b0, 1, res(ST_OK, 0, 0, 6, 1, 0));
    add_row(OP_REMOVE, 32'h1234,     3'd0, 1'b0, 1, res(ST_NOT_FOUND, 0, 0, 0, 1, 0));
    add_row(OP_POP,    32'h0,        3'd0, 1'b0, 1, res(ST_OK, 1, 0, 0, 0, 0));
    add_row(OP_ADD,    32'h5A,       3'd2, 1'b0, 0, '0);
    add_row(OP_ADD,    32'h6B,       3'd4, 1'b0, 0, '0);
    add_row(OP_NOP,    32'h0,        3'd0, 1'b0, 0, '0);
    add_row(OP_POP,    32'h0,        3'd0, 1'b0, 0, '0);

    for (n = 0; n < 8; n++) recent_keys[n] = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 12);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.op, row.key, row.level, row.express, row.typed, row.want);
    end

    // alternate fill and drain phases so queues both overflow and run dry
    filling = 1'b1;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 120 == 0) filling = (n % 240 == 0);
      pick = $urandom_range(0, 99);
      if (filling)
        op = (pick < 70) ? OP_ADD : (pick < 82) ? OP_POP : (pick < 95) ? OP_REMOVE : OP_NOP;
      else
        op = (pick < 25) ? OP_ADD : (pick < 75) ? OP_POP : (pick < 95) ? OP_REMOVE : OP_NOP;
      level   = ($urandom_range(0, 99) < 85) ? LEVEL_W'($urandom_range(1, LEVEL_COUNT))
                                             : LEVEL_W'($urandom_range(0, 7));
      express = ($urandom_range(0, 4) == 0);
      key     = $urandom;
      if (op == OP_ADD) begin
        if ($urandom_range(0, 99) < 40) key = recent_keys[$urandom_range(0, 7)];
        recent_keys[$urandom_range(0, 7)] = key;
      end else if (op == OP_REMOVE && $urandom_range(0, 99) < 75) begin
        key = recent_keys[$urandom_range(0, 7)];
      end
      send_word(op, key, level, express, 0, '0);
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### strict_priority_multi_queue.f
+incdir+design
design/spmq_pkg.sv
design/strict_priority_multi_queue.sv
design/spmq_checker.sv
dv/tb_top.sv
